[design/kpeb_pkg.sv]
// Keypad entry buffer package: key codes, action codes, payload and
// controller/datapath handshake types, and the fixed keypad decode table.
// No dependencies.
`default_nettype none

package kpeb_pkg;

	// ASCII codes used by the decoder and the datapath
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_E     = 8'h45;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned VALUE_W = 32;

	// display action reported with each result word
	typedef enum logic [2:0] {
		ACT_IGNORED   = 3'd0,
		ACT_ECHO      = 3'd1,
		ACT_ERASE_ONE = 3'd2,
		ACT_ERASE_ALL = 3'd3,
		ACT_DONE      = 3'd4
	} action_t;

	// input word: one key press
	typedef struct packed {
		logic [1:0] key_row;
		logic [1:0] key_col;
	} key_in_t;

	// output word: one result per key press
	typedef struct packed {
		logic [CHAR_W-1:0]  key_char;
		action_t            action;
		logic [CHAR_W-1:0]  shown_char;
		logic [LEN_W-1:0]   erase_count;
		logic [LEN_W-1:0]   entry_length;
		logic               entry_done;
		logic [VALUE_W-1:0] entry_value;
	} result_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;    // input word accepted this cycle
		logic walk;    // buffer walk in progress
		logic finish;  // walk complete, value goes to the result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_walk;  // the offered key completes the entry
		logic walk_end;   // all buffer reads issued
		logic rd_busy;    // a buffer read is still in flight
	} dp_status_t;

	// fixed 4x4 keypad layout
	function automatic logic [7:0] key_decode(input logic [1:0] row, input logic [1:0] col);
		logic [7:0] ch;
		ch = CH_0;
		unique case ({row, col})
			4'h0: ch = 8'h31;
			4'h1: ch = 8'h32;
			4'h2: ch = 8'h33;
			4'h3: ch = CH_B;
			4'h4: ch = 8'h34;
			4'h5: ch = 8'h35;
			4'h6: ch = 8'h36;
			4'h7: ch = CH_C;
			4'h8: ch = 8'h37;
			4'h9: ch = 8'h38;
			4'hA: ch = 8'h39;
			4'hB: ch = CH_SPACE;
			4'hC: ch = CH_STAR;
			4'hD: ch = CH_0;
			4'hE: ch = CH_HASH;
			4'hF: ch = CH_E;
			default: ch = CH_0;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[design/kpeb_ctrl.sv]
// Keypad entry buffer controller: state machine for accept and buffer walk,
// plus the output valid flag. Depends on kpeb_pkg.
`default_nettype none

module kpeb_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  kpeb_pkg::dp_status_t  status,
	output kpeb_pkg::dp_cmd_t     cmd
);
	import kpeb_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        take;
	logic        finish;

	// accept only when idle and the result register is free or being emptied
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		cmd.take   = take;
		cmd.walk   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take && status.need_walk) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_end && !status.rd_busy) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.finish = finish;
	end

	// result valid: set on a direct result or end of walk, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((take && !status.need_walk) || finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[design/kpeb_dp.sv]
// Keypad entry buffer datapath: key decode, entry buffer memory, count,
// mask register, decimal accumulator and result register. Depends on kpeb_pkg.
`default_nettype none

module kpeb_dp #(
	parameter int unsigned MAX_LEN = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  kpeb_pkg::key_in_t     in_data,
	input  wire                   cfg_write,
	input  wire                   cfg_data,
	input  kpeb_pkg::dp_cmd_t     cmd,
	output kpeb_pkg::dp_status_t  status,
	output kpeb_pkg::result_t     out_data
);
	import kpeb_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
	localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [CHAR_W-1:0]  mem [MAX_LEN];
	logic               mask_q;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   walk_len_q, walk_len_d;
	logic [CNT_W-1:0]   idx_q;
	logic [CHAR_W-1:0]  rd_data_s1;
	logic               rd_vld_s1;
	logic [VALUE_W-1:0] acc_q;
	logic               issue;
	logic               append;
	logic               need_walk;
	logic [CHAR_W-1:0]  key;
	logic [CNT_W-1:0]   count_inc;
	logic [3:0]         digit;
	logic               is_digit;
	result_t            res_d;
	result_t            res_q;

	// decode the offered key and work out its effect on the entry
	always_comb begin
		key        = key_decode(in_data.key_row, in_data.key_col);
		count_inc  = count_q + CNT_ONE;
		count_d    = count_q;
		walk_len_d = count_q;
		append     = 1'b0;
		need_walk  = 1'b0;
		res_d              = '0;
		res_d.key_char     = key;
		res_d.action       = ACT_IGNORED;
		case (key)
			CH_E: begin
				count_d          = '0;
				need_walk        = 1'b1;
				res_d.action     = ACT_DONE;
				res_d.entry_done = 1'b1;
			end
			CH_B: begin
				if (count_q != '0) begin
					count_d           = count_q - CNT_ONE;
					res_d.action      = ACT_ERASE_ONE;
					res_d.erase_count = LEN_W'(1);
				end
			end
			CH_C: begin
				count_d           = '0;
				res_d.action      = ACT_ERASE_ALL;
				res_d.erase_count = LEN_W'(count_q);
			end
			default: begin
				// count stays below MAX_LEN between words, so an append always fits
				append           = 1'b1;
				res_d.action     = ACT_ECHO;
				res_d.shown_char = mask_q ? CH_STAR : key;
				walk_len_d       = count_inc;
				if (count_inc == CNT_MAX) begin
					count_d          = '0;
					need_walk        = 1'b1;
					res_d.entry_done = 1'b1;
				end else begin
					count_d = count_inc;
				end
			end
		endcase
		res_d.entry_length = LEN_W'(count_d);
	end

	assign issue = cmd.walk && (idx_q != walk_len_q);

	assign status.need_walk = need_walk;
	assign status.walk_end  = (idx_q == walk_len_q);
	assign status.rd_busy   = rd_vld_s1;

	// mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 1'b0;
		end else if (cfg_write) begin
			mask_q <= cfg_data;
		end
	end

	// entry count and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			walk_len_q <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.take) begin
				count_q    <= count_d;
				walk_len_q <= walk_len_d;
				idx_q      <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_ONE;
			end
		end
	end

	// entry buffer: one write port on accept, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (cmd.take && append) begin
			mem[count_q[ADDR_W-1:0]] <= key;
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	// decimal accumulate, times ten as two shifts and an add
	assign is_digit = (rd_data_s1 >= CH_0) && (rd_data_s1 <= CH_9);
	assign digit    = 4'(rd_data_s1 - CH_0);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			acc_q <= '0;
		end else if (rd_vld_s1 && is_digit) begin
			acc_q <= (acc_q << 3) + (acc_q << 1) + VALUE_W'(digit);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_q <= res_d;
		end else if (cmd.finish) begin
			res_q.entry_value <= acc_q;
		end
	end

	assign out_data = res_q;

endmodule

`default_nettype wire

[design/keypad_entry_buffer.sv]
// Keypad entry buffer top level: joins the controller and the datapath.
// Depends on kpeb_pkg, kpeb_ctrl and kpeb_dp.
//
//   channel  signals                         word
//   in       in_valid / in_ready / in_data    key_in_t (key_row, key_col)
//   out      out_valid / out_ready / out_data result_t (one per key press)
//   cfg      cfg_valid / cfg_ready / cfg_data mask_echo bit, always ready
//
// A key that does not complete the entry gives its result in the cycle after
// acceptance. A completing key walks the buffer through its one read port,
// one character per cycle. A new key is taken once the walk ends and the
// result register is free or being read; a stalled result holds. Reset
// empties the entry and clears the mask; buffer contents need no reset.
`default_nettype none

module keypad_entry_buffer #(
	parameter int unsigned MAX_LEN = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  kpeb_pkg::key_in_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output kpeb_pkg::result_t  out_data,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_data
);
	import kpeb_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration is always accepted
	assign cfg_ready = 1'b1;

	kpeb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	kpeb_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_write (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for keypad_entry_buffer: directed and random key presses, each result word
// checked field by field against a behavioral model of the entry buffer kept in this file.
// Depends on kpeb_pkg and keypad_entry_buffer.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kpeb_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int ENTRY_MAX = 16;
	localparam int SETTLE_CYCLES = ENTRY_MAX + 4;
	localparam int CYCLE_LIMIT = 400000;

	// keypad layout, one byte per key; key {row,col} sits at byte row*4+col
	localparam logic [127:0] KEY_LAYOUT = {"E#0*", " 987", "C654", "B321"};
	// non-digit keys that are appended like digits
	localparam logic [23:0] MARK_CHARS = {CH_STAR, CH_HASH, CH_SPACE};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	key_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	result_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	// model of the entry buffer, matching the block's reset state
	logic [7:0] typed_chars [ENTRY_MAX];
	int typed_count = 0;
	logic echo_masked = 1'b0;
	result_t pending_results [$];

	int error_count = 0;
	int words_checked = 0;
	int keys_sent = 0;
	int cycle_count = 0;

	// sender bursts and receiver stall pattern
	bit tx_gaps = 1'b0;
	int tx_burst_left = 0;
	bit rx_stalls = 1'b0;
	logic [15:0] rx_pattern = 16'hA5A5;
	logic [3:0] rx_bit = 4'd0;

	keypad_entry_buffer #(.MAX_LEN(ENTRY_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL keypad_entry_buffer");
			$finish;
		end
	end

	// receiver back-pressure: walk a 16-bit ready pattern, reload it on wrap
	always @(posedge clk) begin
		if (!rx_stalls) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= rx_pattern[rx_bit];
			rx_bit <= rx_bit + 4'd1;
			if (rx_bit == 4'd15) begin
				case ($urandom_range(0, 3))
					0: rx_pattern <= 16'hFFFF;
					1: rx_pattern <= 16'h8000;
					2: rx_pattern <= 16'($urandom());
					default: rx_pattern <= 16'($urandom()) | 16'($urandom());
				endcase
			end
		end
	end

	task automatic report_error(string msg);
		$display("ERROR %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic key_in_t key_for_char(logic [7:0] ch);
		key_in_t key;
		key = '0;
		for (int i = 0; i < 16; i++)
			if (KEY_LAYOUT[i * 8 +: 8] == ch)
				key = key_in_t'(4'(i));
		return key;
	endfunction

	// decimal value of the buffered digits, wrapping at 32 bits
	function automatic logic [31:0] typed_value();
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < typed_count; i++)
			if (typed_chars[i] >= CH_0 && typed_chars[i] <= CH_9)
				v = v * 32'd10 + 32'(typed_chars[i] - CH_0);
		return v;
	endfunction

	// apply one key press to the model and return the word it should produce
	function automatic result_t predict_press(key_in_t key);
		result_t r;
		int slot;
		slot = {key.key_row, key.key_col};
		r = '0;
		r.key_char = KEY_LAYOUT[slot * 8 +: 8];
		r.action = ACT_IGNORED;
		if (r.key_char == CH_E) begin
			r.entry_value = typed_value();
			r.entry_done = 1'b1;
			r.action = ACT_DONE;
			typed_count = 0;
		end else if (r.key_char == CH_B) begin
			// backspace on an empty entry does nothing
			if (typed_count > 0) begin
				typed_count--;
				typed_chars[typed_count] = '0;
				r.action = ACT_ERASE_ONE;
				r.erase_count = 5'd1;
			end
		end else if (r.key_char == CH_C) begin
			r.erase_count = 5'(typed_count);
			typed_count = 0;
			r.action = ACT_ERASE_ALL;
		end else begin
			if (typed_count < ENTRY_MAX) begin
				typed_chars[typed_count] = r.key_char;
				typed_count++;
			end
			r.action = ACT_ECHO;
			r.shown_char = echo_masked ? CH_STAR : r.key_char;
			// a full buffer completes the entry on the same key
			if (typed_count >= ENTRY_MAX) begin
				r.entry_value = typed_value();
				r.entry_done = 1'b1;
				typed_count = 0;
			end
		end
		r.entry_length = 5'(typed_count);
		return r;
	endfunction

	task automatic compare_word(result_t got, result_t want);
		int n;
		n = words_checked;
		if (got.key_char !== want.key_char)
			report_error($sformatf("word %0d key_char %h, expected %h", n,
				got.key_char, want.key_char));
		if (got.action !== want.action)
			report_error($sformatf("word %0d action %0d, expected %0d", n,
				got.action, want.action));
		if (got.shown_char !== want.shown_char)
			report_error($sformatf("word %0d shown_char %h, expected %h", n,
				got.shown_char, want.shown_char));
		if (got.erase_count !== want.erase_count)
			report_error($sformatf("word %0d erase_count %0d, expected %0d", n,
				got.erase_count, want.erase_count));
		if (got.entry_length !== want.entry_length)
			report_error($sformatf("word %0d entry_length %0d, expected %0d", n,
				got.entry_length, want.entry_length));
		if (got.entry_done !== want.entry_done)
			report_error($sformatf("word %0d entry_done %b, expected %b", n,
				got.entry_done, want.entry_done));
		if (got.entry_value !== want.entry_value)
			report_error($sformatf("word %0d entry_value %0d, expected %0d", n,
				got.entry_value, want.entry_value));
	endtask

	// check every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result word %h with none expected", out_data));
			end else begin
				want = pending_results.pop_front();
				compare_word(out_data, want);
			end
			words_checked++;
		end
	end

	// offer one key press, predict its word on acceptance, then maybe pause
	task automatic send_key(key_in_t key);
		int gap;
		in_valid <= 1'b1;
		in_data <= key;
		do @(posedge clk); while (!(in_valid && in_ready));
		pending_results.push_back(predict_press(key));
		keys_sent++;
		if (tx_gaps) begin
			if (tx_burst_left == 0) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				tx_burst_left = $urandom_range(0, 10);
			end else begin
				tx_burst_left--;
			end
		end
	endtask

	task automatic press_string(string keys);
		for (int i = 0; i < keys.len(); i++)
			send_key(key_for_char(keys[i]));
	endtask

	// stop offering, let every word come back and any completion walk finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(logic masked);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= masked;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		echo_masked = masked;
	endtask

	// every key but enter: backspace and clear on an empty entry, then with content;
	// leaves seven characters buffered
	task automatic test_edit_keys();
		write_mask(1'b0);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		press_string("BC123B456C7890*# ");
	endtask

	// masked echo; the buffer fills with a wrapping value, then enter on an empty entry
	task automatic test_full_entry();
		write_mask(1'b1);
		press_string("999999999E");
	endtask

	// mostly well-formed entries with random digits and edits, some random presses
	task automatic test_random_entries(int count, logic masked, bit gaps, bit stalls);
		int stop_at;
		int len;
		bit nines;
		write_mask(masked);
		tx_gaps = gaps;
		tx_burst_left = 0;
		rx_stalls = stalls;
		stop_at = keys_sent + count;
		while (keys_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				send_key(key_in_t'(4'($urandom_range(0, 15))));
			end else begin
				case ($urandom_range(0, 3))
					0: len = ENTRY_MAX;
					1: len = $urandom_range(9, 15);
					default: len = $urandom_range(0, 8);
				endcase
				// all-nines entries can drive the value past 32 bits
				nines = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 15))
						0: send_key(key_for_char(CH_B));
						1: send_key(key_for_char(CH_C));
						2: send_key(key_for_char(MARK_CHARS[8 * $urandom_range(0, 2) +: 8]));
						default: send_key(key_for_char(nines ? CH_9 :
							8'(CH_0 + $urandom_range(0, 9))));
					endcase
				end
				if ($urandom_range(0, 9) != 0)
					send_key(key_for_char(CH_E));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_edit_keys();
		test_full_entry();
		test_random_entries(130, 1'b1, 1'b1, 1'b0);
		test_random_entries(140, 1'b0, 1'b1, 1'b1);
		test_random_entries(140, 1'b1, 1'b1, 1'b1);
		test_random_entries(120, 1'b0, 1'b0, 1'b1);
		wait_idle();
		if (error_count == 0)
			$display("PASS keypad_entry_buffer");
		else
			$display("FAIL keypad_entry_buffer");
		$finish;
	end

endmodule
